/* hw/rtl/tsr_pkg.sv */
package tsr_pkg;

  localparam int unsigned SEGMENT_MAX  = 64;
  localparam int unsigned DATAGRAM_MAX = 2048;
  localparam int unsigned SEG_AW       = $clog2(SEGMENT_MAX);
  localparam int unsigned FILL_W       = $clog2(SEGMENT_MAX + 2);
  localparam int unsigned DG_AW        = $clog2(DATAGRAM_MAX);
  localparam int unsigned EPOCH_W      = 8;
  localparam int unsigned HDR_BYTES    = 6;

  localparam logic [15:0] CRC_INIT  = 16'h1D0F;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [7:0]  CLASS_RST = 8'd85;
  localparam logic [7:0]  KIND_MASK = 8'hF8;
  localparam logic [7:0]  KIND_FIRST = 8'hC0;
  localparam logic [7:0]  KIND_SUBSEQ = 8'hE0;

  typedef enum logic [1:0] {
    OP_SEG   = 2'd0,
    OP_READ  = 2'd1,
    OP_ABORT = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_TAKEN    = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_ACCEPTED = 3'd2,
    ST_COMPLETE = 3'd3,
    ST_READ     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    V_DROP  = 2'd0,
    V_FIRST = 2'd1,
    V_SUB   = 2'd2
  } verdict_e;

  // commands from controller to datapath
  typedef struct packed {
    logic latch;
    logic seg_byte;
    logic abort;
    logic rd_issue;
    logic rd_take;
    logic check;
    logic cp_rd;
    logic cp_wr;
    logic cp_done;
    logic sweep_step;
    logic load_out;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    op_e      op;
    logic     last;
    verdict_e verdict;
    logic     wrap;
    logic     copy_more;
    logic     sweep_last;
  } sts_t;

  // one byte of CRC-16, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* hw/rtl/tsr_in_if.sv */
interface tsr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  byte_value;
  logic        last_of_segment;
  logic [10:0] read_index;

  modport source (output valid, operation, byte_value, last_of_segment, read_index,
                  input ready);
  modport sink (input valid, operation, byte_value, last_of_segment, read_index,
                output ready);
endinterface

/* hw/rtl/tsr_out_if.sv */
interface tsr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  read_data;
  logic [10:0] datagram_length;
  logic [3:0]  session_number;

  modport source (output valid, status, read_data, datagram_length, session_number,
                  input ready);
  modport sink (input valid, status, read_data, datagram_length, session_number,
                output ready);
endinterface

/* hw/rtl/transport_segment_reassembler.sv */
// A segment byte or abort passes EXEC and RESULT; a read passes EXEC, READ and RESULT.
// Input ready returns once the result is loaded, so one item is in flight at a time;
// a new item waits while the result side still holds the previous result.
// A segment's final byte also goes through the header checks; an accepted one then copies each
// payload byte with a read-then-write of the arrival tag memory and then closes the copy.
// Async active-low reset; then a tag clearing pass over all 2048 entries with input ready low, repeated
// after every 255th accepted first segment.
module transport_segment_reassembler (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsr_in_if.sink     seg_in,
  tsr_out_if.source  res_out,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i
);

  tsr_pkg::cmd_t cmd;
  tsr_pkg::sts_t sts;

  tsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (seg_in.valid),
    .in_ready_o  (seg_in.ready),
    .out_valid_o (res_out.valid),
    .out_ready_i (res_out.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tsr_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .operation_i       (seg_in.operation),
    .byte_value_i      (seg_in.byte_value),
    .last_of_segment_i (seg_in.last_of_segment),
    .read_index_i      (seg_in.read_index),
    .status_o          (res_out.status),
    .read_data_o       (res_out.read_data),
    .datagram_length_o (res_out.datagram_length),
    .session_number_o  (res_out.session_number)
  );

endmodule

/* hw/rtl/tsr_ram.sv */
module tsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/tsr_ctrl.sv */
module tsr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  tsr_pkg::sts_t sts_i,
  output tsr_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_CHECK,
    S_CP_RD,
    S_CP_WR,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   sweep_copy_q, sweep_copy_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // sequence one item at a time
  always_comb begin
    cmd_o        = '0;
    state_d      = state_q;
    sweep_copy_d = sweep_copy_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    case (state_q)
      S_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d      = sweep_copy_q ? S_CP_RD : S_IDLE;
          sweep_copy_d = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts_i.op)
          tsr_pkg::OP_SEG: begin
            cmd_o.seg_byte = 1'b1;
            state_d        = sts_i.last ? S_CHECK : S_RESULT;
          end
          tsr_pkg::OP_READ: begin
            cmd_o.rd_issue = 1'b1;
            state_d        = S_READ;
          end
          tsr_pkg::OP_ABORT: begin
            cmd_o.abort = 1'b1;
            state_d     = S_RESULT;
          end
          default: state_d = S_RESULT;
        endcase
      end
      S_READ: begin
        cmd_o.rd_take = 1'b1;
        state_d       = S_RESULT;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        case (sts_i.verdict)
          tsr_pkg::V_FIRST: begin
            if (sts_i.wrap) begin
              state_d      = S_SWEEP;
              sweep_copy_d = 1'b1;
            end else begin
              state_d = S_CP_RD;
            end
          end
          tsr_pkg::V_SUB: state_d = S_CP_RD;
          default:        state_d = S_RESULT;
        endcase
      end
      S_CP_RD: begin
        if (sts_i.copy_more) begin
          cmd_o.cp_rd = 1'b1;
          state_d     = S_CP_WR;
        end else begin
          cmd_o.cp_done = 1'b1;
          state_d       = S_RESULT;
        end
      end
      S_CP_WR: begin
        cmd_o.cp_wr = 1'b1;
        state_d     = S_CP_RD;
      end
      S_RESULT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // hold state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      out_valid_q  <= 1'b0;
      sweep_copy_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      sweep_copy_q <= sweep_copy_d;
    end
  end

endmodule

/* hw/rtl/tsr_dp.sv */
module tsr_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tsr_pkg::cmd_t cmd_i,
  output tsr_pkg::sts_t sts_o,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_data_i,
  input  logic [1:0]    operation_i,
  input  logic [7:0]    byte_value_i,
  input  logic          last_of_segment_i,
  input  logic [10:0]   read_index_i,
  output logic [2:0]    status_o,
  output logic [7:0]    read_data_o,
  output logic [10:0]   datagram_length_o,
  output logic [3:0]    session_number_o
);

  localparam int unsigned FW = tsr_pkg::FILL_W;
  localparam int unsigned AW = tsr_pkg::DG_AW;
  localparam int unsigned EW = tsr_pkg::EPOCH_W;

  // item and configuration
  logic [7:0]  class_q;
  logic [1:0]  op_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [10:0] idx_q;

  // segment buffering
  logic [FW-1:0] fill_q, len_q;
  logic [15:0]   crc_q;
  logic [7:0]    p1_q, p2_q;
  logic [7:0]    hdr_q [tsr_pkg::HDR_BYTES];

  // datagram progress
  logic [10:0]   expected_q;
  logic [3:0]    session_q;
  logic          inprog_q;
  logic [AW:0]   count_q;
  logic [EW-1:0] epoch_q;
  logic [FW-1:0] seg_idx_q, body_q;
  logic [AW:0]   pos_q;
  logic [AW-1:0] sweep_q;
  logic [2:0]    status_q;
  logic [7:0]    rdata_q;

  // result register
  logic [2:0]  out_status_q;
  logic [7:0]  out_data_q;
  logic [10:0] out_len_q;
  logic [3:0]  out_sess_q;

  // memory ports
  logic [7:0]    seg_rd, dg_rd;
  logic [EW-1:0] tag_rd;
  logic          tag_we;
  logic [AW-1:0] tag_waddr, dg_raddr;
  logic [EW-1:0] tag_wdata;
  logic          is_new;

  // segment checks
  logic [FW-1:0]      sat_fill, body;
  logic               base_ok, crc_ok, is_first, is_sub, ext;
  logic [7:0]         kind, ext_len;
  logic [FW-1:0]      head;
  logic [8:0]         start;
  logic               start_bad;
  logic [10:0]        size, offset;
  tsr_pkg::verdict_e  verdict;
  logic [15:0]        crc_base, crc_next;

  assign sat_fill = (fill_q <= FW'(tsr_pkg::SEGMENT_MAX)) ? fill_q + FW'(1) : fill_q;
  assign crc_base = (fill_q == '0) ? tsr_pkg::CRC_INIT : crc_q;
  assign crc_next = (fill_q >= FW'(2)) ? tsr_pkg::crc_byte(crc_base, p2_q) : crc_base;

  // decide the fate of a finished segment
  always_comb begin
    body     = len_q - FW'(2);
    crc_ok   = (crc_q == {p2_q, p1_q});
    base_ok  = (len_q <= FW'(tsr_pkg::SEGMENT_MAX)) && (len_q >= FW'(3)) &&
               (hdr_q[0] == class_q) && crc_ok;
    kind     = hdr_q[1] & tsr_pkg::KIND_MASK;
    is_first = (kind == tsr_pkg::KIND_FIRST);
    is_sub   = (kind == tsr_pkg::KIND_SUBSEQ);
    ext      = hdr_q[3][3];
    head     = is_first ? FW'(4) : FW'(5);
    ext_len  = is_first ? hdr_q[4] : hdr_q[5];
    start    = ext ? 9'(head) + 9'd1 + 9'(ext_len) : 9'(head);
    start_bad = (ext && (body < head + FW'(1))) || (start > 9'(body));
    size     = {hdr_q[1][2:0], hdr_q[2]};
    offset   = {hdr_q[3][2:0], hdr_q[4]};
    verdict  = tsr_pkg::V_DROP;
    if (base_ok && is_first && (body >= FW'(4)) && (size != '0) && !start_bad) begin
      verdict = tsr_pkg::V_FIRST;
    end else if (base_ok && is_sub && inprog_q && (body >= FW'(5)) &&
                 (hdr_q[3][7:4] == session_q) && !start_bad) begin
      verdict = tsr_pkg::V_SUB;
    end
  end

  assign is_new = (tag_rd != epoch_q);

  assign sts_o.op         = tsr_pkg::op_e'(op_q);
  assign sts_o.last       = last_q;
  assign sts_o.verdict    = verdict;
  assign sts_o.wrap       = (epoch_q == '1);
  assign sts_o.copy_more  = (seg_idx_q < body_q) && (pos_q < {1'b0, expected_q});
  assign sts_o.sweep_last = (sweep_q == '1);

  // register updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_q    <= tsr_pkg::CLASS_RST;
      fill_q     <= '0;
      expected_q <= '0;
      session_q  <= '0;
      inprog_q   <= 1'b0;
      count_q    <= '0;
      epoch_q    <= EW'(1);
      sweep_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        class_q <= cfg_data_i;
      end
      if (cmd_i.seg_byte) begin
        fill_q <= last_q ? '0 : sat_fill;
      end
      if (cmd_i.abort) begin
        fill_q     <= '0;
        expected_q <= '0;
        session_q  <= '0;
        inprog_q   <= 1'b0;
        count_q    <= '0;
      end
      if (cmd_i.check && (verdict == tsr_pkg::V_FIRST)) begin
        expected_q <= size;
        session_q  <= hdr_q[3][7:4];
        inprog_q   <= 1'b1;
        count_q    <= '0;
        epoch_q    <= (epoch_q == '1) ? EW'(1) : epoch_q + EW'(1);
      end
      if (cmd_i.cp_wr && is_new) begin
        count_q <= count_q + (AW+1)'(1);
      end
      if (cmd_i.cp_done && (count_q == {1'b0, expected_q})) begin
        inprog_q <= 1'b0;
        count_q  <= '0;
      end
      if (cmd_i.sweep_step) begin
        sweep_q <= sweep_q + AW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q     <= operation_i;
      byte_q   <= byte_value_i;
      last_q   <= last_of_segment_i;
      idx_q    <= read_index_i;
      status_q <= tsr_pkg::ST_TAKEN;
      rdata_q  <= '0;
    end
    if (cmd_i.seg_byte) begin
      len_q <= sat_fill;
      crc_q <= crc_next;
      p2_q  <= p1_q;
      p1_q  <= byte_q;
      if (fill_q < FW'(tsr_pkg::HDR_BYTES)) begin
        hdr_q[fill_q[2:0]] <= byte_q;
      end
    end
    if (cmd_i.rd_take) begin
      status_q <= tsr_pkg::ST_READ;
      rdata_q  <= ((idx_q < expected_q) && !(inprog_q && is_new)) ? dg_rd : 8'd0;
    end
    if (cmd_i.check) begin
      status_q  <= tsr_pkg::ST_DROPPED;
      seg_idx_q <= start[FW-1:0];
      body_q    <= body;
      pos_q     <= (verdict == tsr_pkg::V_SUB) ? {1'b0, offset} : '0;
    end
    if (cmd_i.cp_wr) begin
      seg_idx_q <= seg_idx_q + FW'(1);
      pos_q     <= pos_q + (AW+1)'(1);
    end
    if (cmd_i.cp_done) begin
      status_q <= (count_q == {1'b0, expected_q}) ? tsr_pkg::ST_COMPLETE
                                                   : tsr_pkg::ST_ACCEPTED;
    end
    if (cmd_i.load_out) begin
      out_status_q <= status_q;
      out_data_q   <= rdata_q;
      out_len_q    <= expected_q;
      out_sess_q   <= session_q;
    end
  end

  assign status_o          = out_status_q;
  assign read_data_o       = out_data_q;
  assign datagram_length_o = out_len_q;
  assign session_number_o  = out_sess_q;

  // memory address and write selection
  assign dg_raddr  = cmd_i.rd_issue ? idx_q : pos_q[AW-1:0];
  assign tag_we    = cmd_i.sweep_step || (cmd_i.cp_wr && is_new);
  assign tag_waddr = cmd_i.sweep_step ? sweep_q : pos_q[AW-1:0];
  assign tag_wdata = cmd_i.sweep_step ? '0 : epoch_q;

  tsr_ram #(.WIDTH(8), .DEPTH(tsr_pkg::SEGMENT_MAX)) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.seg_byte && (fill_q < FW'(tsr_pkg::SEGMENT_MAX))),
    .waddr_i (fill_q[tsr_pkg::SEG_AW-1:0]),
    .wdata_i (byte_q),
    .raddr_i (seg_idx_q[tsr_pkg::SEG_AW-1:0]),
    .rdata_o (seg_rd)
  );

  tsr_ram #(.WIDTH(8), .DEPTH(tsr_pkg::DATAGRAM_MAX)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.cp_wr && is_new),
    .waddr_i (pos_q[AW-1:0]),
    .wdata_i (seg_rd),
    .raddr_i (dg_raddr),
    .rdata_o (dg_rd)
  );

  tsr_ram #(.WIDTH(EW), .DEPTH(tsr_pkg::DATAGRAM_MAX)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .raddr_i (dg_raddr),
    .rdata_o (tag_rd)
  );

endmodule
